### src/bmwm_pkg.sv
// shared types and constants for the banked memory window mapper
package bmwm_pkg;

	// bus operation codes
	localparam logic [1:0] OP_MEM_RD = 2'd0;
	localparam logic [1:0] OP_MEM_WR = 2'd1;
	localparam logic [1:0] OP_IO_RD  = 2'd2;
	localparam logic [1:0] OP_IO_WR  = 2'd3;

	// target region codes
	localparam logic [3:0] RG_NONE    = 4'd0;
	localparam logic [3:0] RG_RAM     = 4'd1;
	localparam logic [3:0] RG_VRAM    = 4'd2;
	localparam logic [3:0] RG_EMS     = 4'd3;
	localparam logic [3:0] RG_LEARN   = 4'd4;
	localparam logic [3:0] RG_DIC     = 4'd5;
	localparam logic [3:0] RG_KANJI   = 4'd6;
	localparam logic [3:0] RG_RAMDRV  = 4'd7;
	localparam logic [3:0] RG_MEMCARD = 4'd8;
	localparam logic [3:0] RG_ROMDRV  = 4'd9;
	localparam logic [3:0] RG_IPL     = 4'd10;

	// io port addresses
	localparam logic [15:0] PORT_EMS0   = 16'h08e1;
	localparam logic [15:0] PORT_EMS1   = 16'h08e3;
	localparam logic [15:0] PORT_EMS2   = 16'h08e5;
	localparam logic [15:0] PORT_EMS3   = 16'h08e7;
	localparam logic [15:0] PORT_LEARN  = 16'h0c10;
	localparam logic [15:0] PORT_RDBANK = 16'h0e8e;
	localparam logic [15:0] PORT_RDSEL  = 16'h1e8e;
	localparam logic [15:0] PORT_DIC    = 16'h4c10;
	localparam logic [15:0] PORT_KANJI  = 16'h8c10;
	localparam logic [15:0] PORT_ROMDRV = 16'hcc10;

	// bank limits and select codes
	localparam logic [5:0] DIC_BANKS    = 6'd48;
	localparam logic [6:0] RAMDRV_BANKS = 7'd88;
	localparam logic [7:0] SEL_RAMDRV   = 8'h81;
	localparam logic [7:0] SEL_MEMCARD  = 8'h82;
	localparam logic [7:0] IO_RD_MARK   = 8'h40;
	localparam logic [7:0] IO_RD_IDLE   = 8'hff;

	// current bank register contents
	typedef struct packed {
		logic [3:0][6:0] ems;
		logic [3:0]      learn;
		logic [5:0]      dic;
		logic [3:0]      kanji;
		logic [3:0]      romdrv;
		logic [6:0]      ramdrv;
		logic [7:0]      drive_mode;
	} bank_set_t;

	// one decoded result transaction
	typedef struct packed {
		logic [3:0]  region;
		logic [20:0] offset;
		logic        commit;
		logic [7:0]  wval;
		logic [7:0]  rbyte;
		logic        local_rd;
	} result_t;

endpackage

### src/bmwm_bank_regs.sv
// bank register file loaded by io write transactions
module bmwm_bank_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [15:0]         port,
	input  logic [7:0]          wdata,
	output bmwm_pkg::bank_set_t banks
);
	import bmwm_pkg::*;

	bank_set_t banks_q;

	assign banks = banks_q;

	// port decode and masked load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banks_q.ems[0]     <= 7'd0;
			banks_q.ems[1]     <= 7'd1;
			banks_q.ems[2]     <= 7'd2;
			banks_q.ems[3]     <= 7'd3;
			banks_q.learn      <= '0;
			banks_q.dic        <= '0;
			banks_q.kanji      <= '0;
			banks_q.romdrv     <= '0;
			banks_q.ramdrv     <= '0;
			banks_q.drive_mode <= SEL_RAMDRV;
		end else if (wr_en) begin
			unique case (port)
				PORT_EMS0:   banks_q.ems[0]     <= wdata[6:0];
				PORT_EMS1:   banks_q.ems[1]     <= wdata[6:0];
				PORT_EMS2:   banks_q.ems[2]     <= wdata[6:0];
				PORT_EMS3:   banks_q.ems[3]     <= wdata[6:0];
				PORT_LEARN:  banks_q.learn      <= wdata[3:0];
				PORT_RDBANK: banks_q.ramdrv     <= wdata[6:0];
				PORT_RDSEL:  banks_q.drive_mode <= wdata;
				PORT_DIC:    banks_q.dic        <= wdata[5:0];
				PORT_KANJI:  banks_q.kanji      <= wdata[3:0];
				PORT_ROMDRV: banks_q.romdrv     <= wdata[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule

### src/bmwm_decode.sv
// combinational decode of one bus transaction into a result
module bmwm_decode (
	input  logic [1:0]          op,
	input  logic [19:0]         address,
	input  logic [7:0]          data_byte,
	input  bmwm_pkg::bank_set_t banks,
	output bmwm_pkg::result_t   res
);
	import bmwm_pkg::*;

	logic [3:0]  mem_region;
	logic [20:0] mem_offset;
	logic        mem_writable;
	logic [13:0] low14;
	logic [7:0]  dummy;

	assign low14 = address[13:0];
	// dummy pattern: high byte for odd addresses, low byte for even
	assign dummy = address[0] ? address[15:8] : address[7:0];

	// memory map decode
	always_comb begin
		mem_region   = RG_NONE;
		mem_offset   = '0;
		mem_writable = 1'b0;
		unique case (address[19:16])
			4'ha: begin
				if (address[15]) begin
					mem_region   = RG_VRAM;
					mem_offset   = {6'd0, address[14:0]};
					mem_writable = 1'b1;
				end
			end
			4'hb: begin
			end
			4'hc: begin
				mem_region   = RG_EMS;
				mem_offset   = {banks.ems[address[15:14]], low14};
				mem_writable = 1'b1;
			end
			4'hd: begin
				unique case (address[15:14])
					2'd0: begin
						mem_region   = RG_LEARN;
						mem_offset   = {3'd0, banks.learn, low14};
						mem_writable = 1'b1;
					end
					2'd1: begin
						if (banks.dic < DIC_BANKS) begin
							mem_region = RG_DIC;
							mem_offset = {1'b0, banks.dic, low14};
						end
					end
					2'd2: begin
						mem_region = RG_KANJI;
						mem_offset = {3'd0, banks.kanji, low14};
					end
					default: begin
						// any other select code leaves the window unmapped
						if (banks.drive_mode == SEL_RAMDRV
								&& banks.ramdrv < RAMDRV_BANKS) begin
							mem_region   = RG_RAMDRV;
							mem_offset   = {banks.ramdrv, low14};
							mem_writable = 1'b1;
						end else if (banks.drive_mode == SEL_MEMCARD) begin
							mem_region   = RG_MEMCARD;
							mem_offset   = {banks.ramdrv, low14};
							mem_writable = 1'b1;
						end
					end
				endcase
			end
			4'he: begin
				mem_region = RG_ROMDRV;
				mem_offset = {1'b0, banks.romdrv, address[15:0]};
			end
			4'hf: begin
				mem_region = RG_IPL;
				mem_offset = {5'd0, address[15:0]};
			end
			default: begin
				// below a0000 is main ram
				mem_region   = RG_RAM;
				mem_offset   = {1'b0, address};
				mem_writable = 1'b1;
			end
		endcase
	end

	// result selection per operation
	always_comb begin
		res = '0;
		unique case (op)
			OP_MEM_RD: begin
				res.region = mem_region;
				res.offset = mem_offset;
				if (mem_region == RG_NONE) begin
					res.rbyte    = dummy;
					res.local_rd = 1'b1;
				end
			end
			OP_MEM_WR: begin
				if (mem_writable) begin
					res.region = mem_region;
					res.offset = mem_offset;
					res.commit = 1'b1;
					res.wval   = data_byte;
				end
			end
			OP_IO_RD: begin
				res.local_rd = 1'b1;
				unique case (address[15:0])
					PORT_LEARN:  res.rbyte = {4'd0, banks.learn} | IO_RD_MARK;
					PORT_DIC:    res.rbyte = {2'd0, banks.dic} | IO_RD_MARK;
					PORT_KANJI:  res.rbyte = {4'd0, banks.kanji} | IO_RD_MARK;
					PORT_ROMDRV: res.rbyte = {4'd0, banks.romdrv} | IO_RD_MARK;
					default:     res.rbyte = IO_RD_IDLE;
				endcase
			end
			default: begin
				// io write results are all zero
			end
		endcase
	end

endmodule

### src/banked_memory_window_mapper_top.sv
// top level: input register, decode and bank registers, result register
// two register stages; out_valid rises when an access enters the result register
// throughput: one transaction per cycle, limited only by out_stall
// an io write updates the bank registers as it leaves the input register,
// so the very next transaction already decodes with the new banks
// reset: arst_n clears both valid flags and loads the bank reset values
module banked_memory_window_mapper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [19:0] address,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  target_region,
	output logic [20:0] target_offset,
	output logic        write_commit,
	output logic [7:0]  write_value,
	output logic [7:0]  read_byte,
	output logic        read_local
);
	import bmwm_pkg::*;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [19:0] address_s1;
	logic [7:0]  data_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	bank_set_t   banks;
	logic        adv_s1;
	logic        take_in;

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1      <= op;
			address_s1 <= address;
			data_s1    <= data_byte;
		end
	end

	// bank registers, written as an io write leaves stage 1
	bmwm_bank_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (valid_s1 && adv_s1 && op_s1 == OP_IO_WR),
		.port   (address_s1[15:0]),
		.wdata  (data_s1),
		.banks  (banks)
	);

	bmwm_decode u_decode (
		.op        (op_s1),
		.address   (address_s1),
		.data_byte (data_s1),
		.banks     (banks),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign target_region = res_s2.region;
	assign target_offset = res_s2.offset;
	assign write_commit  = res_s2.commit;
	assign write_value   = res_s2.wval;
	assign read_byte     = res_s2.rbyte;
	assign read_local    = res_s2.local_rd;

endmodule

### sim/window_map_checker.sv
// checker for the window mapper: predicts each decoded access and compares the results
module window_map_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [19:0] address,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  target_region,
	input  logic [20:0] target_offset,
	input  logic        write_commit,
	input  logic [7:0]  write_value,
	input  logic [7:0]  read_byte,
	input  logic        read_local,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import bmwm_pkg::*;

	bank_set_t banks;
	result_t   decoded_q[$];

	// bank registers after an io write; unknown ports leave them alone
	function automatic bank_set_t banks_after_io_write(bank_set_t b, logic [15:0] port,
			logic [7:0] d);
		case (port)
			PORT_EMS0:   b.ems[0] = d[6:0];
			PORT_EMS1:   b.ems[1] = d[6:0];
			PORT_EMS2:   b.ems[2] = d[6:0];
			PORT_EMS3:   b.ems[3] = d[6:0];
			PORT_LEARN:  b.learn = d[3:0];
			PORT_RDBANK: b.ramdrv = d[6:0];
			PORT_RDSEL:  b.drive_mode = d;
			PORT_DIC:    b.dic = d[5:0];
			PORT_KANJI:  b.kanji = d[3:0];
			PORT_ROMDRV: b.romdrv = d[3:0];
			default: ;
		endcase
		return b;
	endfunction

	// decoded result of one access against the current banks
	function automatic result_t decode_access(bank_set_t b, logic [1:0] o, logic [19:0] a,
			logic [7:0] d);
		result_t     r;
		logic [3:0]  region;
		logic [20:0] offset;
		logic        writable;
		r = '0;
		region = RG_NONE;
		offset = '0;
		writable = 1'b0;

		// memory map
		if (a < 20'ha0000) begin
			region = RG_RAM;
			offset = {1'b0, a};
			writable = 1'b1;
		end else if (a >= 20'ha8000 && a < 20'hb0000) begin
			region = RG_VRAM;
			offset = {1'b0, a} - 21'h0a8000;
			writable = 1'b1;
		end else if (a >= 20'hc0000 && a < 20'hd0000) begin
			region = RG_EMS;
			offset = {b.ems[a[15:14]], a[13:0]};
			writable = 1'b1;
		end else if (a >= 20'hd0000 && a < 20'hd4000) begin
			region = RG_LEARN;
			offset = {3'b0, b.learn, a[13:0]};
			writable = 1'b1;
		end else if (a >= 20'hd4000 && a < 20'hd8000) begin
			if (b.dic < DIC_BANKS) begin
				region = RG_DIC;
				offset = {1'b0, b.dic, a[13:0]};
			end
		end else if (a >= 20'hd8000 && a < 20'hdc000) begin
			region = RG_KANJI;
			offset = {3'b0, b.kanji, a[13:0]};
		end else if (a >= 20'hdc000 && a < 20'he0000) begin
			if (b.drive_mode == SEL_RAMDRV && b.ramdrv < RAMDRV_BANKS) begin
				region = RG_RAMDRV;
				offset = {b.ramdrv, a[13:0]};
				writable = 1'b1;
			end else if (b.drive_mode == SEL_MEMCARD) begin
				region = RG_MEMCARD;
				offset = {b.ramdrv, a[13:0]};
				writable = 1'b1;
			end
		end else if (a >= 20'he0000 && a < 20'hf0000) begin
			region = RG_ROMDRV;
			offset = {1'b0, b.romdrv, a[15:0]};
		end else if (a >= 20'hf0000) begin
			region = RG_IPL;
			offset = {5'b0, a[15:0]};
		end

		case (o)
			OP_MEM_RD: begin
				r.region = region;
				r.offset = offset;
				// unmapped reads answer with the dummy byte pattern
				if (region == RG_NONE) begin
					r.rbyte = a[0] ? a[15:8] : a[7:0];
					r.local_rd = 1'b1;
				end
			end
			OP_MEM_WR: begin
				if (writable) begin
					r.region = region;
					r.offset = offset;
					r.commit = 1'b1;
					r.wval = d;
				end
			end
			OP_IO_RD: begin
				r.local_rd = 1'b1;
				case (a[15:0])
					PORT_LEARN:  r.rbyte = {4'b0, b.learn} | IO_RD_MARK;
					PORT_DIC:    r.rbyte = {2'b0, b.dic} | IO_RD_MARK;
					PORT_KANJI:  r.rbyte = {4'b0, b.kanji} | IO_RD_MARK;
					PORT_ROMDRV: r.rbyte = {4'b0, b.romdrv} | IO_RD_MARK;
					default:     r.rbyte = IO_RD_IDLE;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// compare finished transactions first, then predict the newly accepted one
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			banks.ems = {7'd3, 7'd2, 7'd1, 7'd0};
			banks.learn = '0;
			banks.dic = '0;
			banks.kanji = '0;
			banks.romdrv = '0;
			banks.ramdrv = '0;
			banks.drive_mode = SEL_RAMDRV;
			decoded_q.delete();
			mismatches = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (decoded_q.size() == 0) begin
					$error("result transaction arrived with none expected");
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (target_region !== want.region) begin
						$error("target_region: expected %0d, got %0d", want.region,
							target_region);
						mismatches++;
					end
					if (target_offset !== want.offset) begin
						$error("target_offset: expected %h, got %h", want.offset,
							target_offset);
						mismatches++;
					end
					if (write_commit !== want.commit) begin
						$error("write_commit: expected %b, got %b", want.commit, write_commit);
						mismatches++;
					end
					if (write_value !== want.wval) begin
						$error("write_value: expected %h, got %h", want.wval, write_value);
						mismatches++;
					end
					if (read_byte !== want.rbyte) begin
						$error("read_byte: expected %h, got %h", want.rbyte, read_byte);
						mismatches++;
					end
					if (read_local !== want.local_rd) begin
						$error("read_local: expected %b, got %b", want.local_rd, read_local);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				decoded_q.push_back(decode_access(banks, op, address, data_byte));
				if (op == OP_IO_WR)
					banks = banks_after_io_write(banks, address[15:0], data_byte);
			end
			pending = decoded_q.size();
		end
	end

endmodule

### sim/tb.sv
// testbench top: clock, reset, access stimulus, result stalls and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bmwm_pkg::*;

	localparam int unsigned RANDOM_ACCESSES = 1350;
	localparam int unsigned HOLD_CYCLES     = 48;
	localparam int unsigned IDLE_LIMIT      = 1000;
	localparam int unsigned DRAIN_CYCLES    = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [19:0] address;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  target_region;
	logic [20:0] target_offset;
	logic        write_commit;
	logic [7:0]  write_value;
	logic [7:0]  read_byte;
	logic        read_local;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned op_tally[4];
	bit          calm;
	bit          hold_req;

	banked_memory_window_mapper_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.address       (address),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.target_region (target_region),
		.target_offset (target_offset),
		.write_commit  (write_commit),
		.write_value   (write_value),
		.read_byte     (read_byte),
		.read_local    (read_local)
	);

	window_map_checker mapper_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.address       (address),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.target_region (target_region),
		.target_offset (target_offset),
		.write_commit  (write_commit),
		.write_value   (write_value),
		.read_byte     (read_byte),
		.read_local    (read_local),
		.mismatches    (mismatches),
		.pending       (pending),
		.results_seen  (results_seen)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// offer one access after a random gap and hold it until accepted
	task automatic issue(input logic [1:0] o, input logic [19:0] a, input logic [7:0] d);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		address <= a;
		data_byte <= d;
		do @(posedge clk); while (!(in_valid && !in_stall));
		op_tally[o]++;
	endtask

	// drop valid and wait until every decoded access has come back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// random access, mostly aimed at window edges and bank ports
	task automatic random_access(output logic [1:0] o, output logic [19:0] a,
			output logic [7:0] d);
		int unsigned pick;
		logic [19:0] base;
		pick = $urandom_range(0, 99);
		a = 20'($urandom);
		d = 8'($urandom);
		if (pick < 35)
			o = OP_MEM_RD;
		else if (pick < 60)
			o = OP_MEM_WR;
		else if (pick < 72)
			o = OP_IO_RD;
		else
			o = OP_IO_WR;

		if (o <= OP_MEM_WR && $urandom_range(0, 4) != 0) begin
			case ($urandom_range(0, 17))
				0:  base = 20'h00000;
				1:  base = 20'h9c000;
				2:  base = 20'ha0000;
				3:  base = 20'ha8000;
				4:  base = 20'hac000;
				5:  base = 20'hb0000;
				6:  base = 20'hc0000;
				7:  base = 20'hc4000;
				8:  base = 20'hc8000;
				9:  base = 20'hcc000;
				10: base = 20'hd0000;
				11: base = 20'hd4000;
				12: base = 20'hd8000;
				13: base = 20'hdc000;
				14: base = 20'he0000;
				15: base = 20'hec000;
				16: base = 20'hf0000;
				default: base = 20'hfc000;
			endcase
			a = base | {6'b0, a[13:0]};
		end else if (o >= OP_IO_RD && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 9))
				0: a[15:0] = PORT_EMS0;
				1: a[15:0] = PORT_EMS1;
				2: a[15:0] = PORT_EMS2;
				3: a[15:0] = PORT_EMS3;
				4: a[15:0] = PORT_LEARN;
				5: a[15:0] = PORT_RDBANK;
				6: a[15:0] = PORT_RDSEL;
				7: a[15:0] = PORT_DIC;
				8: a[15:0] = PORT_KANJI;
				default: a[15:0] = PORT_ROMDRV;
			endcase
			// steer the ram-drive select toward its meaningful codes
			if (o == OP_IO_WR && a[15:0] == PORT_RDSEL) begin
				case ($urandom_range(0, 3))
					0: d = SEL_RAMDRV;
					1: d = SEL_MEMCARD;
					2: d = 8'h80;
					default: ;
				endcase
			end
		end
	endtask

	// result side: random stalls per transaction, one long hold on request
	initial begin
		int unsigned stall_cycles;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall_cycles = calm ? 0 : $urandom_range(0, 8);
			if (stall_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [1:0]  o;
		logic [19:0] a;
		logic [7:0]  d;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_MEM_RD;
		address <= '0;
		data_byte <= '0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// region edges, dummy pattern, discarded writes and the bank ports other than ems 0 to 2
		issue(OP_MEM_RD, 20'h00000, 8'h00);
		issue(OP_MEM_WR, 20'h9ffff, 8'hff);
		issue(OP_MEM_RD, 20'ha0000, 8'h00);
		issue(OP_MEM_RD, 20'ha7fff, 8'h00);
		issue(OP_MEM_WR, 20'haffff, 8'h00);
		issue(OP_MEM_RD, 20'hbffff, 8'h00);
		issue(OP_IO_WR, {4'h0, PORT_EMS3}, 8'hff);
		issue(OP_MEM_WR, 20'hcffff, 8'ha5);
		issue(OP_IO_WR, {4'hf, PORT_LEARN}, 8'hff);
		issue(OP_IO_RD, {4'h0, PORT_LEARN}, 8'h00);
		issue(OP_IO_WR, {4'h0, PORT_DIC}, 8'hff);
		issue(OP_IO_RD, {4'h0, PORT_DIC}, 8'h00);
		issue(OP_MEM_RD, 20'hd4000, 8'h00);
		issue(OP_IO_WR, {4'h0, PORT_DIC}, 8'h2f);
		issue(OP_MEM_RD, 20'hd7fff, 8'h00);
		issue(OP_IO_WR, {4'h0, PORT_KANJI}, 8'hff);
		issue(OP_MEM_WR, 20'hd8000, 8'h11);
		issue(OP_IO_WR, {4'h0, PORT_RDBANK}, 8'h58);
		issue(OP_MEM_RD, 20'hdc000, 8'h00);
		issue(OP_IO_WR, {4'h0, PORT_RDSEL}, SEL_MEMCARD);
		issue(OP_MEM_WR, 20'hdffff, 8'h3c);
		issue(OP_IO_WR, {4'h0, PORT_RDSEL}, 8'h80);
		issue(OP_MEM_WR, 20'hdc001, 8'h77);
		issue(OP_IO_WR, {4'h0, PORT_ROMDRV}, 8'hff);
		issue(OP_MEM_WR, 20'heffff, 8'h99);
		issue(OP_MEM_RD, 20'hfffff, 8'h00);
		issue(OP_IO_RD, 20'h01234, 8'h00);
		issue(OP_IO_WR, 20'hfffff, 8'h00);
		wait_for_drain();

		// random accesses with quiet stretches, one long result hold and one drain
		for (int unsigned idx = 0; idx < RANDOM_ACCESSES; idx++) begin
			calm = ((idx % 300) >= 200 && (idx % 300) < 260) || (idx >= 600 && idx < 680);
			if (idx == 600)
				hold_req = 1'b1;
			if (idx == 900)
				wait_for_drain();
			random_access(o, a, d);
			issue(o, a, d);
		end
		in_valid <= 1'b0;

		// let everything come back, then wait out DRAIN_CYCLES for strays
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d memory reads, %0d memory writes, %0d io reads, %0d io writes",
			op_tally[OP_MEM_RD], op_tally[OP_MEM_WR], op_tally[OP_IO_RD], op_tally[OP_IO_WR]);
		$display("%0d decoded results compared, %0d field mismatches", results_seen,
			mismatches);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
src/bmwm_pkg.sv
src/bmwm_bank_regs.sv
src/bmwm_decode.sv
src/banked_memory_window_mapper_top.sv
sim/window_map_checker.sv
sim/tb.sv
